// File: hw/rtl/rgbds_pkg.sv
// Shared types, constants and colour expansion functions for the RGB565 downscaler.
`default_nettype none

package rgbds_pkg;

    // Configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int SRC_REG_W  = 11;
    localparam int DST_REG_W  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

    localparam logic [SRC_REG_W-1:0] SRC_WIDTH_RST  = 11'd240;
    localparam logic [SRC_REG_W-1:0] SRC_HEIGHT_RST = 11'd240;
    localparam logic [DST_REG_W-1:0] DST_WIDTH_RST  = 10'd160;
    localparam logic [DST_REG_W-1:0] DST_HEIGHT_RST = 10'd120;

    // Fraction bits of the Q16 step and accumulators
    localparam int FRAC_W = 16;

    // Default size limits
    localparam int MAX_SRC_DIM_DEF = 1024;
    localparam int MAX_DST_DIM_DEF = 512;

    // Stream word widths
    localparam int PIX_W  = 16;
    localparam int CHAN_W = 8;
    localparam int OUT_W  = 3 * CHAN_W;

    // Controller states
    typedef enum logic [2:0] {
        ST_COL_START,
        ST_COL_WAIT,
        ST_ROW_START,
        ST_ROW_WAIT,
        ST_RUN
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic div_start;
        logic div_row;
        logic wr_col_step;
        logic wr_row_step;
        logic run;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic cfg_hit;
    } stat_t;

    // Expand 5-bit channel: (c*255+15)/31 through a reciprocal multiply (2^18 scale)
    function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] c);
        logic [12:0] x;
        logic [26:0] prod;
        begin
            x    = ({c, 8'd0} - {8'd0, c}) + 13'd15;
            prod = {14'd0, x} * 27'd8457;
            return prod[25:18];
        end
    endfunction

    // Expand 6-bit channel: (c*255+31)/63 through a reciprocal multiply (2^20 scale)
    function automatic logic [CHAN_W-1:0] expand6(input logic [5:0] c);
        logic [13:0] x;
        logic [28:0] prod;
        begin
            x    = ({c, 8'd0} - {8'd0, c}) + 14'd31;
            prod = {15'd0, x} * 29'd16645;
            return prod[27:20];
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rgbds_div.sv
// Restoring divider, one quotient bit per cycle, for the Q16 step values.
`default_nettype none

module rgbds_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 9
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quot,
    output logic                  busy,
    output logic                  done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    // Shift in the next dividend bit and trial-subtract
    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quot_next = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_next = {quot_reg[NUM_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign quot = quot_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rgbds_ctrl.sv
// Controller: works out the column and row steps, then lets pixels through.
`default_nettype none

module rgbds_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rgbds_pkg::stat_t stat,
    output rgbds_pkg::cmd_t     cmd
);

    rgbds_pkg::state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rgbds_pkg::ST_COL_START: state_next = rgbds_pkg::ST_COL_WAIT;
            rgbds_pkg::ST_COL_WAIT:
                if (stat.div_done)
                    state_next = rgbds_pkg::ST_ROW_START;
            rgbds_pkg::ST_ROW_START: state_next = rgbds_pkg::ST_ROW_WAIT;
            rgbds_pkg::ST_ROW_WAIT:
                if (stat.div_done)
                    state_next = rgbds_pkg::ST_RUN;
            rgbds_pkg::ST_RUN:       state_next = rgbds_pkg::ST_RUN;
            default:                 state_next = rgbds_pkg::ST_COL_START;
        endcase
        // A register write restarts the step computation
        if (stat.cfg_hit)
            state_next = rgbds_pkg::ST_COL_START;
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            rgbds_pkg::ST_COL_START: cmd.div_start = 1'b1;
            rgbds_pkg::ST_COL_WAIT:  cmd.wr_col_step = stat.div_done;
            rgbds_pkg::ST_ROW_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_row   = 1'b1;
            end
            rgbds_pkg::ST_ROW_WAIT:
            begin
                cmd.div_row     = 1'b1;
                cmd.wr_row_step = stat.div_done;
            end
            rgbds_pkg::ST_RUN:       cmd.run = 1'b1;
            default:                 cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rgbds_pkg::ST_COL_START;
        else
            state_reg <= state_next;
    end

    // A register write always lands back at the start of the step computation
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        stat.cfg_hit |=> state_reg == rgbds_pkg::ST_COL_START)
        else $error("register write did not restart step computation");

endmodule

`default_nettype wire

// File: hw/rtl/rgbds_dp.sv
// Datapath: config registers, step divider, position counters and output register.
`default_nettype none

module rgbds_dp #(
    parameter int MAX_SRC_DIM = rgbds_pkg::MAX_SRC_DIM_DEF,
    parameter int MAX_DST_DIM = rgbds_pkg::MAX_DST_DIM_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rgbds_pkg::PIX_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [rgbds_pkg::OUT_W-1:0]    m_tdata,
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rgbds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgbds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire rgbds_pkg::cmd_t                cmd,
    output rgbds_pkg::stat_t                    stat
);

    localparam int FRAC_W    = rgbds_pkg::FRAC_W;
    localparam int SRC_DIM_W = $clog2(MAX_SRC_DIM + 1);
    localparam int SRC_IDX_W = $clog2(MAX_SRC_DIM);
    localparam int DST_DIM_W = $clog2(MAX_DST_DIM + 1);
    localparam int DEN_W     = $clog2(MAX_DST_DIM);
    localparam int STEP_W    = SRC_IDX_W + FRAC_W;
    localparam int ACC_W     = STEP_W + 1;
    localparam int CMP_A     = (SRC_DIM_W > DST_DIM_W) ? SRC_DIM_W : DST_DIM_W;
    localparam int CMP_W     = (CMP_A > rgbds_pkg::SRC_REG_W) ? CMP_A : rgbds_pkg::SRC_REG_W;
    localparam int PIX_W_L   = rgbds_pkg::PIX_W;

    localparam logic [CMP_W-1:0] MAX_SRC_C = CMP_W'(MAX_SRC_DIM);
    localparam logic [CMP_W-1:0] MAX_DST_C = CMP_W'(MAX_DST_DIM);
    localparam logic [CMP_W-1:0] ONE_C     = CMP_W'(1);

    logic [rgbds_pkg::SRC_REG_W-1:0] src_width_reg, src_height_reg;
    logic [rgbds_pkg::DST_REG_W-1:0] dst_width_reg, dst_height_reg;

    logic [STEP_W-1:0]    col_step_reg, row_step_reg;
    logic [SRC_IDX_W-1:0] src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [DST_DIM_W-1:0] out_col_reg, out_col_next, out_row_reg, out_row_next;
    logic [ACC_W-1:0]     col_accum_reg, col_accum_next, row_accum_reg, row_accum_next;

    logic                 out_valid_reg, out_valid_next;
    logic [rgbds_pkg::CHAN_W-1:0] red_reg, green_reg, blue_reg;
    logic                 last_reg;

    logic [CMP_W-1:0] sw_raw, sh_raw, dw_raw, dh_raw;
    logic [CMP_W-1:0] sw_c, sh_c, dw_l, dh_l, dw_c, dh_c;
    logic [CMP_W-1:0] sw_m1_c, sh_m1_c, dw_m1_c, dh_m1_c;
    logic [SRC_IDX_W-1:0] sw_m1, sh_m1;
    logic [DEN_W-1:0]     dw_m1, dh_m1, div_den;
    logic [DST_DIM_W-1:0] dw, dh, dw_last, dh_last;
    logic [STEP_W-1:0]    div_num, div_quot;
    logic                 div_busy, div_done;

    logic                 cfg_hit, accept, row_hit, emit, last_flag;
    logic [PIX_W_L-1:0]   pix;

    // Clamp the programmed sizes
    assign sw_raw = CMP_W'(src_width_reg);
    assign sh_raw = CMP_W'(src_height_reg);
    assign dw_raw = CMP_W'(dst_width_reg);
    assign dh_raw = CMP_W'(dst_height_reg);

    assign sw_c = (sw_raw == '0) ? ONE_C : ((sw_raw > MAX_SRC_C) ? MAX_SRC_C : sw_raw);
    assign sh_c = (sh_raw == '0) ? ONE_C : ((sh_raw > MAX_SRC_C) ? MAX_SRC_C : sh_raw);
    assign dw_l = (dw_raw == '0) ? ONE_C : ((dw_raw > MAX_DST_C) ? MAX_DST_C : dw_raw);
    assign dh_l = (dh_raw == '0) ? ONE_C : ((dh_raw > MAX_DST_C) ? MAX_DST_C : dh_raw);
    assign dw_c = (dw_l > sw_c) ? sw_c : dw_l;
    assign dh_c = (dh_l > sh_c) ? sh_c : dh_l;

    assign sw_m1_c = sw_c - ONE_C;
    assign sh_m1_c = sh_c - ONE_C;
    assign dw_m1_c = dw_c - ONE_C;
    assign dh_m1_c = dh_c - ONE_C;

    assign sw_m1   = sw_m1_c[SRC_IDX_W-1:0];
    assign sh_m1   = sh_m1_c[SRC_IDX_W-1:0];
    assign dw_m1   = dw_m1_c[DEN_W-1:0];
    assign dh_m1   = dh_m1_c[DEN_W-1:0];
    assign dw      = dw_c[DST_DIM_W-1:0];
    assign dh      = dh_c[DST_DIM_W-1:0];
    assign dw_last = dw_m1_c[DST_DIM_W-1:0];
    assign dh_last = dh_m1_c[DST_DIM_W-1:0];

    // Step divider: ((src-1) << 16) / (dst-1)
    assign div_num = cmd.div_row ? {sh_m1, {FRAC_W{1'b0}}} : {sw_m1, {FRAC_W{1'b0}}};
    assign div_den = cmd.div_row ? dh_m1 : dw_m1;

    rgbds_div #(
        .NUM_W (STEP_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .busy  (div_busy),
        .done  (div_done)
    );

    // Configuration writes; unknown indexes are dropped
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == rgbds_pkg::REG_SRC_WIDTH
                                  || cfg_index == rgbds_pkg::REG_SRC_HEIGHT
                                  || cfg_index == rgbds_pkg::REG_DST_WIDTH
                                  || cfg_index == rgbds_pkg::REG_DST_HEIGHT);

    assign stat.div_done = div_done;
    assign stat.cfg_hit  = cfg_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= rgbds_pkg::SRC_WIDTH_RST;
            src_height_reg <= rgbds_pkg::SRC_HEIGHT_RST;
            dst_width_reg  <= rgbds_pkg::DST_WIDTH_RST;
            dst_height_reg <= rgbds_pkg::DST_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rgbds_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                rgbds_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                rgbds_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data[rgbds_pkg::DST_REG_W-1:0];
                rgbds_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data[rgbds_pkg::DST_REG_W-1:0];
                default:                   src_width_reg  <= src_width_reg;
            endcase
        end
    end

    // Latch the steps; a single destination pixel means a zero step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_step_reg <= '0;
            row_step_reg <= '0;
        end
        else
        begin
            if (cmd.wr_col_step)
                col_step_reg <= (dw_m1 == '0) ? '0 : div_quot;
            if (cmd.wr_row_step)
                row_step_reg <= (dh_m1 == '0) ? '0 : div_quot;
        end
    end

    // Pick test for the incoming source pixel
    assign s_tready = cmd.run && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign row_hit  = (out_row_reg < dh)
                   && ({1'b0, src_row_reg} == row_accum_reg[ACC_W-1:FRAC_W]);
    assign emit     = row_hit && (out_col_reg < dw)
                   && ({1'b0, src_col_reg} == col_accum_reg[ACC_W-1:FRAC_W]);
    assign last_flag = (out_row_reg == dh_last) && (out_col_reg == dw_last);

    // Advance the raster position and the accumulators
    always_comb
    begin
        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        col_accum_next = col_accum_reg;
        row_accum_next = row_accum_reg;
        if (cfg_hit)
        begin
            src_col_next   = '0;
            src_row_next   = '0;
            out_col_next   = '0;
            out_row_next   = '0;
            col_accum_next = '0;
            row_accum_next = '0;
        end
        else if (accept)
        begin
            if (emit)
            begin
                out_col_next   = out_col_reg + DST_DIM_W'(1);
                col_accum_next = col_accum_reg + ACC_W'(col_step_reg);
            end
            if (src_col_reg >= sw_m1)
            begin
                src_col_next   = '0;
                out_col_next   = '0;
                col_accum_next = '0;
                if (row_hit)
                begin
                    out_row_next   = out_row_reg + DST_DIM_W'(1);
                    row_accum_next = row_accum_reg + ACC_W'(row_step_reg);
                end
                if (src_row_reg >= sh_m1)
                begin
                    src_row_next   = '0;
                    out_row_next   = '0;
                    row_accum_next = '0;
                end
                else
                begin
                    src_row_next = src_row_reg + SRC_IDX_W'(1);
                end
            end
            else
            begin
                src_col_next = src_col_reg + SRC_IDX_W'(1);
            end
        end
    end

    // Output word hand-off
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (accept && emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            col_accum_reg <= '0;
            row_accum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            col_accum_reg <= col_accum_next;
            row_accum_reg <= row_accum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Swap bytes back and expand to RGB888
    assign pix = {s_tdata[7:0], s_tdata[15:8]};

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            red_reg   <= rgbds_pkg::expand5(pix[15:11]);
            green_reg <= rgbds_pkg::expand6(pix[10:5]);
            blue_reg  <= rgbds_pkg::expand5(pix[4:0]);
            last_reg  <= last_flag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};
    assign m_tlast  = last_reg;

    // Pixels only enter once both steps are latched
    a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> cmd.run && !div_busy)
        else $error("pixel accepted while steps not ready");

    // Output column never runs past the destination width
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run |-> out_col_reg <= dw)
        else $error("output column beyond destination width");

    // A picked pixel always lands in the output register
    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit |=> out_valid_reg)
        else $error("picked pixel lost");

endmodule

`default_nettype wire

// File: hw/rtl/rgb565_downscale_to_rgb888.sv
// A picked pixel appears on the master side in the cycle after it is accepted.
// Throughput: one source pixel per cycle while the output word is taken.
// After reset or any register write, the serial step divider (one quotient bit a cycle)
// works out the column step and then the row step before the first pixel is accepted.
// Reset (rst_n, asynchronous, active low) loads 240x240 -> 160x120 and clears position.
`default_nettype none

module rgb565_downscale_to_rgb888 #(
    parameter int MAX_SRC_DIM = rgbds_pkg::MAX_SRC_DIM_DEF,
    parameter int MAX_DST_DIM = rgbds_pkg::MAX_DST_DIM_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [rgbds_pkg::PIX_W-1:0]      s_tdata,    // [15:0] pixel_raw
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [rgbds_pkg::OUT_W-1:0]      m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    output logic                                  m_tlast,    // frame_last
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rgbds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgbds_pkg::CFG_DATA_W-1:0] cfg_data
);

    rgbds_pkg::cmd_t  cmd;
    rgbds_pkg::stat_t stat;

    rgbds_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    rgbds_dp #(
        .MAX_SRC_DIM (MAX_SRC_DIM),
        .MAX_DST_DIM (MAX_DST_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
